// File: rtl/core/tmm_pkg.sv
// shared types and constants of the touch to midi note mapper
package tmm_pkg;

    localparam logic [1:0] OP_ON   = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_OFF  = 2'd2;
    localparam logic [1:0] OP_IDLE = 2'd3;

    localparam logic [1:0] CFG_SENSOR_COUNT      = 2'd0;
    localparam logic [1:0] CFG_OCTAVE_NUMBER     = 2'd1;
    localparam logic [1:0] CFG_PRESSURE_MODE     = 2'd2;
    localparam logic [1:0] CFG_CONTROLLER_NUMBER = 2'd3;

    localparam logic [1:0] MODE_CC      = 2'd0;
    localparam logic [1:0] MODE_POLY    = 2'd1;
    localparam logic [1:0] MODE_CHANNEL = 2'd2;

    localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
    localparam logic [3:0] ST_NOTE_ON   = 4'h9;
    localparam logic [3:0] ST_POLY_PRES = 4'hA;
    localparam logic [3:0] ST_CTRL      = 4'hB;
    localparam logic [3:0] ST_CHAN_PRES = 4'hD;
    localparam logic [3:0] ST_BEND      = 4'hE;

    localparam logic [6:0]  VEL_FULL     = 7'h7f;
    localparam logic [6:0]  CTL_LSB_MAX  = 7'h0d;
    localparam logic [13:0] BEND_CENTER  = 14'h1fff;
    localparam logic [13:0] BEND_MAX     = 14'h3fff;
    localparam logic [1:0]  LEN_TWO      = 2'd2;
    localparam logic [1:0]  LEN_THREE    = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] blob_id;
        logic [3:0]  group_id;
        logic [15:0] position;
        logic [13:0] pressure;
        logic [15:0] frame_offset;
    } t_event;

    typedef struct packed {
        logic [7:0]  status_byte;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [1:0]  message_length;
        logic [15:0] frame_offset_out;
        logic        last_message;
    } t_msg;

    typedef struct packed {
        logic [31:0] blob_id;
        logic [3:0]  channel;
        logic [6:0]  key;
    } t_slot;

endpackage

// File: rtl/core/tmm_ram.sv
// generic single write port ram with registered read
module tmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/touch_to_midi_note_mapper_core.sv
// top level of the touch to midi note mapper: slot table, pitch math and message sequencer
//
// An event is taken when start is high and busy is low; busy then stays high until every
// message of the event has been strobed out. Messages appear on o_result with o_strobe and
// cannot be held off, and no new event is taken while busy is high. An event passes through
// the pitch and key arithmetic states S_CALC0 to S_CALC4, a scan of the slot ram with a read
// and a compare per slot, a 28-step restoring divider for the pitch bend and then its
// messages. Events that send no message, or find no slot, finish after the scan; an idle
// event clears the table in its accepting cycle.
module touch_to_midi_note_mapper_core
    import tmm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_event     i_event,
    output logic       o_strobe,
    output t_msg       o_result,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [4:0] {
        S_IDLE, S_CALC0, S_CALC1, S_CALC2, S_CALC3, S_CALC4,
        S_RD, S_CMP, S_MISS, S_HIT, S_ON, S_BEND0, S_DIV, S_BEND,
        S_CCL, S_CCM, S_POLY, S_CHAN
    } t_state;

    t_state r_state;

    logic [7:0] r_sensor_count;
    logic [3:0] r_octave_number;
    logic [1:0] r_pressure_mode;
    logic [6:0] r_controller_number;

    t_event             r_evt;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_free_idx;
    logic               r_free_found;
    logic [23:0]        r_prod;
    logic [7:0]         r_q;
    logic [4:0]         r_mod;
    logic [29:0]        r_s;
    logic [10:0]        r_v;
    logic [6:0]         r_key_new;
    logic [3:0]         r_ch;
    logic [6:0]         r_key;
    logic [29:0]        r_t;
    logic [11:0]        r_rem;
    logic [27:0]        r_dvd;
    logic [4:0]         r_cnt;
    logic [13:0]        r_bend;
    logic               r_strobe;
    t_msg               r_result;

    t_slot              ram_rdata;
    t_slot              ram_wdata;
    logic               ram_we;

    logic [19:0] q_prod;
    logic [26:0] k_prod;
    logic [9:0]  k_full;
    logic [12:0] trial;
    logic [11:0] divisor;
    logic        hit;

    assign ram_we = (r_state == S_ON);
    assign ram_wdata = '{blob_id: r_evt.blob_id, channel: r_evt.group_id, key: r_key_new};

    tmm_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_ENTRIES)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_idx),
        .i_wdata(ram_wdata),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    assign q_prod  = 20'(r_sensor_count) * 20'd3641;
    assign k_prod  = 27'(r_v) * 27'd43691;
    assign k_full  = k_prod[26:17];
    assign divisor = {r_sensor_count, 4'b0000};
    assign trial   = {r_rem, r_dvd[27]};
    assign hit     = r_valid[r_idx] && (ram_rdata.blob_id == r_evt.blob_id);
    assign busy    = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    function automatic t_msg fn_msg(input logic [3:0] hi, input logic [3:0] ch,
                                    input logic [6:0] d1, input logic [6:0] d2,
                                    input logic [1:0] len, input logic last,
                                    input logic [15:0] fr);
        t_msg m;
        m.status_byte      = {hi, ch};
        m.data_one         = d1;
        m.data_two         = d2;
        m.message_length   = len;
        m.frame_offset_out = fr;
        m.last_message     = last;
        return m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_count      <= 8'd160;
            r_octave_number     <= 4'd2;
            r_pressure_mode     <= MODE_CC;
            r_controller_number <= 7'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SENSOR_COUNT:      r_sensor_count      <= i_cfg_data;
                CFG_OCTAVE_NUMBER:     r_octave_number     <= i_cfg_data[3:0];
                CFG_PRESSURE_MODE:     r_pressure_mode     <= i_cfg_data[1:0];
                CFG_CONTROLLER_NUMBER: r_controller_number <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_evt <= i_event;
                        if (i_event.operation == OP_IDLE) begin
                            r_valid <= '0;
                        end else begin
                            r_state <= S_CALC0;
                        end
                    end
                end
                S_CALC0: begin
                    r_prod  <= 24'(r_evt.position) * 24'(r_sensor_count);
                    r_q     <= {4'b0000, q_prod[19:16]};
                    r_state <= S_CALC1;
                end
                S_CALC1: begin
                    r_mod   <= 5'(r_sensor_count - 8'(r_q * 8'd18));
                    r_state <= S_CALC2;
                end
                S_CALC2: begin
                    r_s <= 30'(r_octave_number) * 30'd4718592 + {5'b0, r_prod, 1'b0}
                         - 30'd196608 - {9'b0, r_mod, 16'b0};
                    r_state <= S_CALC3;
                end
                S_CALC3: begin
                    r_v     <= r_s[29] ? 11'd0 : r_s[27:17];
                    r_state <= S_CALC4;
                end
                S_CALC4: begin
                    r_key_new    <= (k_full > 10'd127) ? 7'd127 : k_full[6:0];
                    r_idx        <= '0;
                    r_free_found <= 1'b0;
                    r_state      <= S_RD;
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!r_valid[r_idx] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_idx;
                    end
                    if (hit) begin
                        r_ch    <= ram_rdata.channel;
                        r_key   <= ram_rdata.key;
                        r_state <= S_HIT;
                    end else if (r_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_MISS;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_MISS: begin
                    if (r_evt.operation == OP_ON && r_free_found) begin
                        r_idx   <= r_free_idx;
                        r_state <= S_ON;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_HIT: begin
                    case (r_evt.operation)
                        OP_OFF: begin
                            r_valid[r_idx] <= 1'b0;
                            r_strobe <= 1'b1;
                            r_result <= fn_msg(ST_NOTE_OFF, r_ch, r_key, VEL_FULL,
                                               LEN_THREE, 1'b1, r_evt.frame_offset);
                            r_state  <= S_IDLE;
                        end
                        OP_ON:   r_state <= S_ON;
                        default: r_state <= S_BEND0;
                    endcase
                end
                S_ON: begin
                    r_valid[r_idx] <= 1'b1;
                    r_ch     <= r_evt.group_id;
                    r_key    <= r_key_new;
                    r_strobe <= 1'b1;
                    r_result <= fn_msg(ST_NOTE_ON, r_evt.group_id, r_key_new, VEL_FULL,
                                       LEN_THREE, 1'b0, r_evt.frame_offset);
                    r_state  <= S_BEND0;
                end
                S_BEND0: begin
                    r_t <= r_s - 30'(r_key) * 30'd393216 + 30'(r_sensor_count) * 30'd131056;
                    r_state <= S_DIV;
                    r_cnt   <= '0;
                    r_rem   <= '0;
                end
                S_DIV: begin
                    if (r_sensor_count == 8'd0) begin
                        r_bend  <= BEND_CENTER;
                        r_state <= S_BEND;
                    end else if (r_t[29]) begin
                        r_bend  <= '0;
                        r_state <= S_BEND;
                    end else if (r_cnt == 5'd0) begin
                        r_dvd <= r_t[27:0];
                        r_cnt <= 5'd1;
                    end else begin
                        if (trial >= {1'b0, divisor}) begin
                            r_rem <= 12'(trial - {1'b0, divisor});
                            r_dvd <= {r_dvd[26:0], 1'b1};
                        end else begin
                            r_rem <= trial[11:0];
                            r_dvd <= {r_dvd[26:0], 1'b0};
                        end
                        if (r_cnt == 5'd28) begin
                            r_state <= S_BEND;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                        r_bend <= BEND_MAX;
                    end
                end
                S_BEND: begin
                    logic [13:0] b;
                    b = r_bend;
                    if (r_sensor_count != 8'd0 && !r_t[29]) begin
                        b = (r_dvd > 28'(BEND_MAX)) ? BEND_MAX : r_dvd[13:0];
                    end
                    r_strobe <= 1'b1;
                    r_result <= fn_msg(ST_BEND, r_ch, b[6:0], b[13:7], LEN_THREE,
                                       r_pressure_mode == 2'd3, r_evt.frame_offset);
                    case (r_pressure_mode)
                        MODE_CC:      r_state <= (r_controller_number <= CTL_LSB_MAX) ?
                                                 S_CCL : S_CCM;
                        MODE_POLY:    r_state <= S_POLY;
                        MODE_CHANNEL: r_state <= S_CHAN;
                        default:      r_state <= S_IDLE;
                    endcase
                end
                S_CCL: begin
                    r_strobe <= 1'b1;
                    r_result <= fn_msg(ST_CTRL, r_ch, r_controller_number | 7'h20,
                                       r_evt.pressure[6:0], LEN_THREE, 1'b0,
                                       r_evt.frame_offset);
                    r_state  <= S_CCM;
                end
                S_CCM: begin
                    r_strobe <= 1'b1;
                    r_result <= fn_msg(ST_CTRL, r_ch, r_controller_number,
                                       r_evt.pressure[13:7], LEN_THREE, 1'b1,
                                       r_evt.frame_offset);
                    r_state  <= S_IDLE;
                end
                S_POLY: begin
                    r_strobe <= 1'b1;
                    r_result <= fn_msg(ST_POLY_PRES, r_ch, r_key, r_evt.pressure[13:7],
                                       LEN_THREE, 1'b1, r_evt.frame_offset);
                    r_state  <= S_IDLE;
                end
                S_CHAN: begin
                    r_strobe <= 1'b1;
                    r_result <= fn_msg(ST_CHAN_PRES, r_ch, r_evt.pressure[13:7], 7'd0,
                                       LEN_TWO, 1'b1, r_evt.frame_offset);
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_message |=> !o_strobe)
        else $error("message after last message of a transaction");

    a_short_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.message_length == LEN_TWO |-> o_result.last_message)
        else $error("two byte message not last");

    a_idle_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_event.operation == OP_IDLE |=> r_valid == '0)
        else $error("idle transaction left slots valid");

endmodule

// File: tb/sv/tb.sv
// testbench of the touch to midi note mapper core: drives touch events and checks midi messages
module tb;
    import tmm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int PITCH_UNIT = 393216;
    localparam int WATCHDOG_LIMIT = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_event     i_event;
    logic       o_strobe;
    t_msg       o_result;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    touch_to_midi_note_mapper_core #(.TABLE_ENTRIES(SLOTS)) dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  sensors;
    logic [3:0]  octave;
    logic [1:0]  pmode;
    logic [6:0]  ctl_num;
    logic        slot_used [SLOTS];
    logic [31:0] slot_id   [SLOTS];
    logic [3:0]  slot_chn  [SLOTS];
    logic [6:0]  slot_key  [SLOTS];

    t_msg midi_expected [$];
    int   errors = 0;
    int   idle_cycles = 0;
    logic [31:0] live_ids [$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic int find_slot(input logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_id[i] == id) return i;
        return -1;
    endfunction

    function automatic t_msg make_msg(input logic [7:0] st, input logic [6:0] d1,
                                      input logic [6:0] d2, input logic [1:0] len,
                                      input logic [15:0] fr);
        t_msg m;
        m.status_byte = st;
        m.data_one = d1;
        m.data_two = (len == LEN_THREE) ? d2 : 7'd0;
        m.message_length = len;
        m.frame_offset_out = fr;
        m.last_message = 1'b0;
        return m;
    endfunction

    task automatic predict_messages(input t_event ev);
        longint n, s, t, b, k;
        int slot;
        logic [6:0] key;
        logic [3:0] chn;
        logic [13:0] bend;
        t_msg batch [$];
        n = sensors;
        s = longint'(octave) * 72 * 65536 - 3 * 65536 - (n % 18) * 65536
            + 2 * longint'(ev.position) * n;
        if (ev.operation == OP_IDLE) begin
            for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
            return;
        end
        if (ev.operation == OP_OFF) begin
            slot = find_slot(ev.blob_id);
            if (slot < 0) return;
            slot_used[slot] = 1'b0;
            batch.push_back(make_msg({ST_NOTE_OFF, slot_chn[slot]}, slot_key[slot], VEL_FULL,
                                     LEN_THREE, ev.frame_offset));
        end else begin
            if (ev.operation == OP_ON) begin
                slot = find_slot(ev.blob_id);
                if (slot < 0)
                    for (int i = SLOTS - 1; i >= 0; i--) if (!slot_used[i]) slot = i;
                if (slot < 0) return;
                if (s < 0) k = 0;
                else begin
                    k = s / PITCH_UNIT;
                    if (k > 127) k = 127;
                end
                slot_used[slot] = 1'b1;
                slot_id[slot] = ev.blob_id;
                slot_chn[slot] = ev.group_id;
                slot_key[slot] = k[6:0];
                batch.push_back(make_msg({ST_NOTE_ON, ev.group_id}, k[6:0], VEL_FULL,
                                         LEN_THREE, ev.frame_offset));
            end
            slot = find_slot(ev.blob_id);
            if (slot < 0) return;
            chn = slot_chn[slot];
            key = slot_key[slot];
            if (n == 0) bend = BEND_CENTER;
            else begin
                t = s - longint'(key) * PITCH_UNIT + 8191 * 16 * n;
                if (t < 0) b = 0;
                else begin
                    b = t / (16 * n);
                    if (b > 16383) b = 16383;
                end
                bend = b[13:0];
            end
            batch.push_back(make_msg({ST_BEND, chn}, bend[6:0], bend[13:7], LEN_THREE,
                                     ev.frame_offset));
            if (pmode == MODE_CC) begin
                if (ctl_num <= CTL_LSB_MAX)
                    batch.push_back(make_msg({ST_CTRL, chn}, 7'h20 | ctl_num,
                                             ev.pressure[6:0], LEN_THREE, ev.frame_offset));
                batch.push_back(make_msg({ST_CTRL, chn}, ctl_num, ev.pressure[13:7],
                                         LEN_THREE, ev.frame_offset));
            end else if (pmode == MODE_POLY) begin
                batch.push_back(make_msg({ST_POLY_PRES, chn}, key, ev.pressure[13:7],
                                         LEN_THREE, ev.frame_offset));
            end else if (pmode == MODE_CHANNEL) begin
                batch.push_back(make_msg({ST_CHAN_PRES, chn}, ev.pressure[13:7], 7'd0,
                                         LEN_TWO, ev.frame_offset));
            end
        end
        batch[batch.size() - 1].last_message = 1'b1;
        foreach (batch[i]) midi_expected.push_back(batch[i]);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (midi_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected message %h", o_result));
            end else begin
                t_msg e;
                e = midi_expected.pop_front();
                if (o_result.status_byte !== e.status_byte)
                    report_mismatch($sformatf("status %h exp %h", o_result.status_byte,
                                              e.status_byte));
                if (o_result.data_one !== e.data_one)
                    report_mismatch($sformatf("data one %h exp %h", o_result.data_one,
                                              e.data_one));
                if (o_result.data_two !== e.data_two)
                    report_mismatch($sformatf("data two %h exp %h", o_result.data_two,
                                              e.data_two));
                if (o_result.message_length !== e.message_length)
                    report_mismatch($sformatf("length %h exp %h", o_result.message_length,
                                              e.message_length));
                if (o_result.frame_offset_out !== e.frame_offset_out)
                    report_mismatch($sformatf("frame %h exp %h", o_result.frame_offset_out,
                                              e.frame_offset_out));
                if (o_result.last_message !== e.last_message)
                    report_mismatch($sformatf("last %b exp %b", o_result.last_message,
                                              e.last_message));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_event(input t_event ev);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_event <= ev;
        do @(posedge i_clk); while (busy);
        predict_messages(ev);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (midi_expected.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SENSOR_COUNT:      sensors = val;
            CFG_OCTAVE_NUMBER:     octave = val[3:0];
            CFG_PRESSURE_MODE:     pmode = val[1:0];
            CFG_CONTROLLER_NUMBER: ctl_num = val[6:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] n, input logic [3:0] o, input logic [1:0] m,
                             input logic [6:0] c);
        drain();
        write_reg(CFG_SENSOR_COUNT, n);
        write_reg(CFG_OCTAVE_NUMBER, {4'd0, o});
        write_reg(CFG_PRESSURE_MODE, {6'd0, m});
        write_reg(CFG_CONTROLLER_NUMBER, {1'b0, c});
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_event make_event(input logic [1:0] op, input logic [31:0] id,
                                          input logic [3:0] grp, input logic [15:0] pos,
                                          input logic [13:0] pres);
        t_event ev;
        ev.operation = op;
        ev.blob_id = id;
        ev.group_id = grp;
        ev.position = pos;
        ev.pressure = pres;
        ev.frame_offset = 16'($urandom);
        return ev;
    endfunction

    task automatic test_directed();
        send_event(make_event(OP_ON, 32'd0, 4'd0, 16'd0, 14'd0));
        send_event(make_event(OP_SET, 32'd0, 4'd5, 16'hffff, 14'h3fff));
        send_event(make_event(OP_ON, 32'hffffffff, 4'hf, 16'hffff, 14'h2aaa));
        send_event(make_event(OP_ON, 32'd0, 4'd3, 16'h8000, 14'h1555));
        send_event(make_event(OP_SET, 32'h1234, 4'd1, 16'd7, 14'd9));
        send_event(make_event(OP_OFF, 32'h1234, 4'd1, 16'd7, 14'd9));
        send_event(make_event(OP_OFF, 32'd0, 4'd0, 16'd0, 14'd0));
        send_event(make_event(OP_OFF, 32'hffffffff, 4'd0, 16'd0, 14'd0));
        // fill the table, then one more on is dropped
        for (int i = 0; i < SLOTS + 1; i++)
            send_event(make_event(OP_ON, 32'h100 + i, 4'(i), 16'(i * 3000), 14'(i * 900)));
        send_event(make_event(OP_IDLE, 32'd0, 4'd0, 16'd0, 14'd0));
        send_event(make_event(OP_SET, 32'h100, 4'd0, 16'd0, 14'd0));
    endtask

    task automatic test_modes_and_extremes();
        configure(8'd16, 4'd0, MODE_POLY, 7'd0);
        send_event(make_event(OP_ON, 32'h7, 4'd2, 16'd0, 14'h3fff));
        send_event(make_event(OP_SET, 32'h7, 4'd2, 16'hffff, 14'h0));
        configure(8'd160, 4'd10, MODE_CHANNEL, 7'd127);
        send_event(make_event(OP_ON, 32'h8, 4'd9, 16'hffff, 14'h3fff));
        send_event(make_event(OP_SET, 32'h8, 4'd9, 16'd0, 14'h7f));
        configure(8'd0, 4'd15, 2'd3, 7'd13);
        send_event(make_event(OP_ON, 32'h9, 4'd4, 16'h4000, 14'd1));
        configure(8'd255, 4'd5, MODE_CC, 7'd13);
        send_event(make_event(OP_ON, 32'ha, 4'd6, 16'h1234, 14'h2345));
        configure(8'd97, 4'd3, MODE_CC, 7'd14);
        send_event(make_event(OP_SET, 32'ha, 4'd6, 16'hc000, 14'h1abc));
        send_event(make_event(OP_IDLE, 32'd0, 4'd0, 16'd0, 14'd0));
    endtask

    task automatic test_random(input int count);
        t_event ev;
        logic [31:0] id;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 39) begin
                drain();
                configure(8'($urandom_range(16, 160)), 4'($urandom_range(0, 10)),
                          2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
            end
            if (live_ids.size() == 0 || $urandom_range(0, 3) == 0) begin
                id = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 20));
                ev = make_event(OP_ON, id, 4'($urandom), 16'($urandom), 14'($urandom));
                live_ids.push_back(id);
            end else begin
                int j;
                j = $urandom_range(0, live_ids.size() - 1);
                case ($urandom_range(0, 9))
                    0, 1: begin
                        ev = make_event(OP_OFF, live_ids[j], 4'($urandom), 16'($urandom),
                                        14'($urandom));
                        live_ids.delete(j);
                    end
                    2: begin
                        ev = make_event($urandom_range(0, 9) == 0 ? OP_IDLE : OP_SET,
                                        $urandom, 4'($urandom), 16'($urandom),
                                        14'($urandom));
                        if (ev.operation == OP_IDLE) live_ids.delete();
                    end
                    default: ev = make_event(OP_SET, live_ids[j], 4'($urandom),
                                             16'($urandom), 14'($urandom));
                endcase
            end
            send_event(ev);
        end
    endtask

    initial begin
        start = 1'b0;
        i_event = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        sensors = 8'd160;
        octave = 4'd2;
        pmode = MODE_CC;
        ctl_num = 7'd7;
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_id[i] = '0;
            slot_chn[i] = '0;
            slot_key[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_modes_and_extremes();
        configure(8'd160, 4'd2, MODE_CC, 7'd3);
        test_random(90);
        drain();
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/tmm_pkg.sv
rtl/core/tmm_ram.sv
rtl/core/touch_to_midi_note_mapper_core.sv
tb/sv/tb.sv
